>>> rtl/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg
// types and constants shared by the cave automaton step block
// ----------------------------------------------------------------------------
package cas_pkg;

   localparam int unsigned MaxHeight     = 64;
   localparam int unsigned ColumnWidth   = 64;
   localparam int unsigned HeightWidth   = 7;
   localparam int unsigned ThreshWidth   = 4;
   localparam int unsigned CountWidth    = 4;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 7;

   localparam logic [CsrIndexWidth-1:0] RegColumnHeight = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegSurviveMin   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] RegBirthMin     = 2'd2;
   localparam logic [CsrIndexWidth-1:0] RegBorderAlive  = 2'd3;

   localparam logic [HeightWidth-1:0] HeightReset  = 7'd50;
   localparam logic [ThreshWidth-1:0] SurviveReset = 4'd1;
   localparam logic [ThreshWidth-1:0] BirthReset   = 4'd4;
   localparam logic                   BorderReset  = 1'b1;

   typedef logic [ColumnWidth-1:0] column_type;

   typedef struct packed {
      logic [ThreshWidth-1:0] survive_min;
      logic [ThreshWidth-1:0] birth_min;
      logic                   border_alive;
   } rule_type;

   typedef struct packed {
      logic       final_column;
      column_type bits;
   } result_type;

endpackage

>>> rtl/cas_lane.sv
// ----------------------------------------------------------------------------
// cas_lane
// one cell of the next generation: neighbour count and survive/birth rule
// ----------------------------------------------------------------------------
module cas_lane (
   input  logic [2:0]       left_cells,
   input  logic [2:0]       right_cells,
   input  logic [1:0]       middle_nbrs,
   input  logic             middle_cell,
   input  cas_pkg::rule_type rule,
   output logic             next_cell
);

   logic [cas_pkg::CountWidth-1:0] count;

   always_comb begin
      count = 4'(left_cells[0]) + 4'(left_cells[1]) + 4'(left_cells[2])
            + 4'(right_cells[0]) + 4'(right_cells[1]) + 4'(right_cells[2])
            + 4'(middle_nbrs[0]) + 4'(middle_nbrs[1]);
      if (middle_cell) begin
         next_cell = (count >= rule.survive_min);
      end else begin
         next_cell = (count >= rule.birth_min);
      end
   end

endmodule

>>> rtl/cas_gen.sv
// ----------------------------------------------------------------------------
// cas_gen
// row of cell lanes over three columns, merged into one result column
// ----------------------------------------------------------------------------
module cas_gen (
   input  cas_pkg::column_type left_col,
   input  cas_pkg::column_type middle_col,
   input  cas_pkg::column_type right_col,
   input  cas_pkg::column_type height_mask,
   input  cas_pkg::rule_type   rule,
   output cas_pkg::column_type next_col
);

   localparam int unsigned ExtWidth = cas_pkg::ColumnWidth + 2;

   cas_pkg::column_type   border_fill;
   logic [ExtWidth-1:0]   left_ext;
   logic [ExtWidth-1:0]   middle_ext;
   logic [ExtWidth-1:0]   right_ext;
   cas_pkg::column_type   lane_next;

   // rows outside the grid read as the border value
   assign border_fill = {cas_pkg::ColumnWidth{rule.border_alive}} & ~height_mask;
   assign left_ext    = {rule.border_alive, (left_col & height_mask) | border_fill,
                         rule.border_alive};
   assign middle_ext  = {rule.border_alive, (middle_col & height_mask) | border_fill,
                         rule.border_alive};
   assign right_ext   = {rule.border_alive, (right_col & height_mask) | border_fill,
                         rule.border_alive};

   for (genvar k = 0; k < cas_pkg::ColumnWidth; k++) begin : g_lane
      cas_lane u_lane (
         .left_cells  (left_ext[k+2:k]),
         .right_cells (right_ext[k+2:k]),
         .middle_nbrs ({middle_ext[k+2], middle_ext[k]}),
         .middle_cell (middle_ext[k+1]),
         .rule        (rule),
         .next_cell   (lane_next[k])
      );
   end

   // merge: unused rows forced to zero
   assign next_col = lane_next & height_mask;

endmodule

>>> rtl/cas_rsp_fifo.sv
// ----------------------------------------------------------------------------
// cas_rsp_fifo
// two-entry result queue between the lane array and the result channel
// ----------------------------------------------------------------------------
module cas_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  cas_pkg::result_type  push_data,
   output logic                 can_push,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cas_pkg::result_type  out_data
);

   cas_pkg::result_type entry_ff [2];
   logic                wr_ptr_ff;
   logic                wr_ptr_in;
   logic                rd_ptr_ff;
   logic                rd_ptr_in;
   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   logic                pop;

   assign can_push  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/cave_automaton_step_top.sv
// ----------------------------------------------------------------------------
// cave_automaton_step_top
// one generation of a binary cave cellular automaton over a column stream
// ----------------------------------------------------------------------------
// Takes one grid column per cycle while the result queue has room and no
// final column is pending; returns the next generation of the column before
// it, so results lag input by one column. The column marked last returns both
// the pending column and itself, and input is held off while the shared
// 64-lane cell array computes that final column (not for a single-column
// grid). A two-entry result queue lets a column enter while an earlier
// result still waits. Registers are written through the always-ready csr channel.
module cave_automaton_step_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // csr port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cas_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [cas_pkg::CsrDataWidth-1:0]      csr_data,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [cas_pkg::ColumnWidth-1:0]       req_tdata,   // column_bits
   input  logic                                  req_tlast,   // last_column
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [cas_pkg::ColumnWidth-1:0]       rsp_tdata,   // new_column_bits
   output logic                                  rsp_tlast    // final_column
);

   logic [cas_pkg::HeightWidth-1:0] height_ff;
   logic [cas_pkg::HeightWidth-1:0] height_in;
   cas_pkg::rule_type               rule_ff;
   cas_pkg::rule_type               rule_in;

   cas_pkg::column_type left_ff;
   cas_pkg::column_type left_in;
   cas_pkg::column_type middle_ff;
   cas_pkg::column_type middle_in;
   logic                middle_valid_ff;
   logic                middle_valid_in;
   logic                middle_first_ff;
   logic                middle_first_in;
   logic                flush_ff;
   logic                flush_in;

   logic [cas_pkg::HeightWidth-1:0] used_height;
   cas_pkg::column_type             height_mask;
   cas_pkg::column_type             border_col;
   cas_pkg::column_type             gen_left;
   cas_pkg::column_type             gen_middle;
   cas_pkg::column_type             gen_right;
   cas_pkg::column_type             gen_next;

   logic                fifo_space;
   logic                accept;
   logic                flush_go;
   logic                push_valid;
   cas_pkg::result_type push_data;
   cas_pkg::result_type out_data;

   // config registers
   assign csr_ready = 1'b1;

   always_comb begin
      height_in = height_ff;
      rule_in   = rule_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cas_pkg::RegColumnHeight: height_in = csr_data;
            cas_pkg::RegSurviveMin:   rule_in.survive_min = csr_data[cas_pkg::ThreshWidth-1:0];
            cas_pkg::RegBirthMin:     rule_in.birth_min = csr_data[cas_pkg::ThreshWidth-1:0];
            cas_pkg::RegBorderAlive:  rule_in.border_alive = csr_data[0];
            default:                  height_in = height_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff            <= cas_pkg::HeightReset;
         rule_ff.survive_min  <= cas_pkg::SurviveReset;
         rule_ff.birth_min    <= cas_pkg::BirthReset;
         rule_ff.border_alive <= cas_pkg::BorderReset;
      end else begin
         height_ff <= height_in;
         rule_ff   <= rule_in;
      end
   end

   // height clamp and row mask
   always_comb begin
      priority if (height_ff == '0) begin
         used_height = 7'd1;
      end else if (height_ff > 7'(cas_pkg::MaxHeight)) begin
         used_height = 7'(cas_pkg::MaxHeight);
      end else begin
         used_height = height_ff;
      end
   end

   for (genvar k = 0; k < cas_pkg::ColumnWidth; k++) begin : g_mask
      assign height_mask[k] = (7'(k) < used_height);
   end

   assign border_col = {cas_pkg::ColumnWidth{rule_ff.border_alive}};

   // handshake
   assign req_tready = !flush_ff && fifo_space;
   assign accept     = req_tvalid && req_tready;
   assign flush_go   = flush_ff && fifo_space;

   // operand select and column window update
   always_comb begin
      gen_left        = middle_first_ff ? border_col : left_ff;
      gen_middle      = middle_ff;
      gen_right       = req_tdata;
      push_valid      = 1'b0;
      push_data.final_column = 1'b0;
      left_in         = left_ff;
      middle_in       = middle_ff;
      middle_valid_in = middle_valid_ff;
      middle_first_in = middle_first_ff;
      flush_in        = flush_ff;

      priority if (flush_go) begin
         gen_right              = border_col;
         push_valid             = 1'b1;
         push_data.final_column = 1'b1;
         middle_valid_in        = 1'b0;
         middle_first_in        = 1'b1;
         flush_in               = 1'b0;
      end else if (accept && middle_valid_ff) begin
         push_valid      = 1'b1;
         left_in         = middle_ff;
         middle_in       = req_tdata;
         middle_first_in = 1'b0;
         flush_in        = req_tlast;
      end else if (accept && req_tlast) begin
         gen_left               = border_col;
         gen_middle             = req_tdata;
         gen_right              = border_col;
         push_valid             = 1'b1;
         push_data.final_column = 1'b1;
      end else if (accept) begin
         middle_in       = req_tdata;
         middle_valid_in = 1'b1;
         middle_first_in = 1'b1;
      end else begin
         flush_in = flush_ff;
      end
      push_data.bits = gen_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         middle_valid_ff <= 1'b0;
         middle_first_ff <= 1'b1;
         flush_ff        <= 1'b0;
      end else begin
         middle_valid_ff <= middle_valid_in;
         middle_first_ff <= middle_first_in;
         flush_ff        <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      middle_ff <= middle_in;
   end

   cas_gen u_gen (
      .left_col    (gen_left),
      .middle_col  (gen_middle),
      .right_col   (gen_right),
      .height_mask (height_mask),
      .rule        (rule_ff),
      .next_col    (gen_next)
   );

   cas_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .can_push   (fifo_space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   assign rsp_tdata = out_data.bits;
   assign rsp_tlast = out_data.final_column;

`ifndef SYNTHESIS
   a_flush_blocks_input: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> !req_tready)
      else $error("input accepted while final column pending");

   a_last_starts_flush: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast && middle_valid_ff) |=> flush_ff)
      else $error("last column with pending column did not start flush");

   a_flush_clears_window: assert property (@(posedge clock) disable iff (reset)
      flush_go |=> (!flush_ff && !middle_valid_ff && middle_first_ff))
      else $error("column window not cleared after final column");
`endif

endmodule

>>> verif/cave_automaton_step_top_test.sv
// ----------------------------------------------------------------------------
// cave_automaton_step_top_test
// self-checking bench for one cave automaton generation over a column stream
// ----------------------------------------------------------------------------
// Streams grids one column per transaction and recomputes every next
// generation column in a behavioural model of the stencil, with its own copy
// of the held columns and the rule registers. A short table covers reset
// rules, height extremes, thresholds past eight, single-column grids, unused
// column bits and a rule change in the middle of a grid; random grids of
// mixed length and density follow, each batch under new random rules and one
// of four patterns of request gaps and response back-pressure.
// ----------------------------------------------------------------------------
module cave_automaton_step_top_test;
   import cas_pkg::*;

   localparam int IdleLimit    = 1000;
   localparam int SettleCycles = 4;
   localparam int PhaseItems   = 250;
   localparam int PhaseCount   = 8;

   typedef struct packed {
      logic                     is_write;
      logic [CsrIndexWidth-1:0] reg_index;
      logic [CsrDataWidth-1:0]  reg_value;
      column_type               column;
      logic                     last;
      logic                     known;
      column_type               known_bits;
   } stim_row;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index  = RegColumnHeight;
   logic [CsrDataWidth-1:0]  csr_data   = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   column_type               req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   column_type               rsp_tdata;
   logic                     rsp_tlast;

   // rule registers as the block should hold them
   logic [HeightWidth-1:0] height_reg  = HeightReset;
   logic [ThreshWidth-1:0] survive_reg = SurviveReset;
   logic [ThreshWidth-1:0] birth_reg   = BirthReset;
   logic                   border_reg  = BorderReset;

   // columns held while waiting for the right neighbour
   column_type prior_column  = '0;
   column_type held_column   = '0;
   logic       column_held   = 1'b0;
   logic       held_is_first = 1'b1;

   result_type awaited_columns[$];
   int         fault_count   = 0;
   int         idle_cycles   = 0;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   logic       row_known     = 1'b0;
   column_type row_known_bits = '0;

   cave_automaton_step_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(1, 100) > rsp_stall_pct);
   end

   function automatic int rows_in_use();
      if (height_reg == 0) return 1;
      if (height_reg > MaxHeight) return MaxHeight;
      return int'(height_reg);
   endfunction

   function automatic int neighbour_cell(column_type col, int row, int rows);
      if (row < 0 || row >= rows) return int'(border_reg);
      return int'(col[row]);
   endfunction

   function automatic column_type edge_column();
      return {ColumnWidth{border_reg}};
   endfunction

   function automatic column_type evolve_column(column_type lft, column_type mid,
                                                column_type rgt);
      int         rows;
      int         count;
      column_type keep;
      column_type outcome;
      rows = rows_in_use();
      keep = (rows >= ColumnWidth) ? '1 : (column_type'(1) << rows) - 1;
      lft &= keep;
      mid &= keep;
      rgt &= keep;
      outcome = '0;
      for (int k = 0; k < rows; k++) begin
         count = 0;
         for (int d = -1; d <= 1; d++) begin
            count += neighbour_cell(lft, k + d, rows);
            count += neighbour_cell(rgt, k + d, rows);
            if (d != 0) count += neighbour_cell(mid, k + d, rows);
         end
         if (mid[k]) outcome[k] = (count >= int'(survive_reg));
         else outcome[k] = (count >= int'(birth_reg));
      end
      return outcome;
   endfunction

   function automatic void advance_grid(column_type col, logic last);
      result_type r;
      column_type lft;
      if (column_held) begin
         lft = held_is_first ? edge_column() : prior_column;
         r.bits = evolve_column(lft, held_column, col);
         r.final_column = 1'b0;
         awaited_columns = {awaited_columns, r};
         prior_column = held_column;
         held_is_first = 1'b0;
      end else begin
         prior_column = '0;
         held_is_first = 1'b1;
      end
      held_column = col;
      column_held = 1'b1;
      if (last) begin
         lft = held_is_first ? edge_column() : prior_column;
         r.bits = evolve_column(lft, held_column, edge_column());
         r.final_column = 1'b1;
         awaited_columns = {awaited_columns, r};
         prior_column = '0;
         held_column = '0;
         column_held = 1'b0;
         held_is_first = 1'b1;
      end
   endfunction

   function automatic void report(string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegColumnHeight: height_reg = csr_data;
               RegSurviveMin:   survive_reg = csr_data[ThreshWidth-1:0];
               RegBirthMin:     birth_reg = csr_data[ThreshWidth-1:0];
               RegBorderAlive:  border_reg = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            advance_grid(req_tdata, req_tlast);
            if (row_known) begin
               want.bits = row_known_bits;
               want.final_column = 1'b1;
               awaited_columns[awaited_columns.size() - 1] = want;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_columns.size() == 0) begin
               report($sformatf("unexpected result: bits %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               want = awaited_columns.pop_front();
               if (rsp_tdata !== want.bits || rsp_tlast !== want.final_column)
                  report($sformatf("mismatch: expected bits %h last %b, got bits %h last %b",
                                   want.bits, want.final_column, rsp_tdata, rsp_tlast));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
          (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic stim_row write_row(logic [CsrIndexWidth-1:0] idx,
                                         logic [CsrDataWidth-1:0] value);
      stim_row r;
      r = '0;
      r.is_write = 1'b1;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   function automatic stim_row column_row(column_type col, logic last);
      stim_row r;
      r = '0;
      r.column = col;
      r.last = last;
      return r;
   endfunction

   // single-column grid whose outcome is plain from the rules
   function automatic stim_row known_row(column_type col, column_type outcome);
      stim_row r;
      r = column_row(col, 1'b1);
      r.known = 1'b1;
      r.known_bits = outcome;
      return r;
   endfunction

   function automatic column_type random_column();
      column_type a;
      column_type b;
      column_type c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return a & b & c;
         1: return a | b | c;
         default: return a;
      endcase
   endfunction

   function automatic logic [CsrDataWidth-1:0] random_threshold();
      if ($urandom_range(0, 3) == 0) return CsrDataWidth'($urandom_range(0, 127));
      return CsrDataWidth'($urandom_range(0, 9));
   endfunction

   task automatic send_column(column_type col, logic last, logic known, column_type outcome);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata = {$urandom, $urandom};
         req_tlast = 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = col;
      req_tlast = last;
      row_known = known;
      row_known_bits = outcome;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // rules change only with no result outstanding
   task automatic settle();
      req_tvalid = 1'b0;
      while (awaited_columns.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      stim_row directed[$];
      int      sent;
      int      grid_len;
      int      height_pick;

      directed = {directed, known_row(64'hFFFC_0000_0000_0000, 64'h0003_FFFF_FFFF_FFFF)};
      directed = {directed, known_row('1, 64'h0003_FFFF_FFFF_FFFF)};
      directed = {directed, column_row(64'h0123_4567_89AB_CDEF, 1'b0)};
      directed = {directed, column_row(64'hFEDC_BA98_7654_3210, 1'b0)};
      directed = {directed, column_row(64'hA5A5_5A5A_0FF0_F00F, 1'b1)};
      directed = {directed, write_row(RegColumnHeight, 7'd64)};
      directed = {directed, write_row(RegBorderAlive, 7'd0)};
      directed = {directed, known_row('0, '0)};
      directed = {directed, known_row('1, '1)};
      directed = {directed, column_row('1, 1'b0)};
      directed = {directed, column_row('0, 1'b1)};
      // thresholds past eight
      directed = {directed, write_row(RegSurviveMin, 7'd9)};
      directed = {directed, write_row(RegBirthMin, 7'd9)};
      directed = {directed, known_row(64'hDEAD_BEEF_CAFE_F00D, '0)};
      directed = {directed, write_row(RegSurviveMin, 7'h7F)};
      directed = {directed, write_row(RegBirthMin, 7'd8)};
      directed = {directed, column_row(64'h8000_0000_0000_0001, 1'b0)};
      directed = {directed, column_row(64'h7FFF_FFFF_FFFF_FFFE, 1'b1)};
      directed = {directed, write_row(RegSurviveMin, 7'd0)};
      directed = {directed, write_row(RegBirthMin, 7'd0)};
      directed = {directed, write_row(RegBorderAlive, 7'd1)};
      directed = {directed, known_row(64'h5555_5555_5555_5555, '1)};
      // zero height acts as one row
      directed = {directed, write_row(RegColumnHeight, 7'd0)};
      directed = {directed, known_row(64'hFFFF_FFFF_FFFF_FFFE, 64'h1)};
      directed = {directed, write_row(RegSurviveMin, 7'd3)};
      directed = {directed, write_row(RegBirthMin, 7'd3)};
      directed = {directed, column_row(64'h1, 1'b0)};
      directed = {directed, column_row(64'h0, 1'b0)};
      directed = {directed, column_row(64'h1, 1'b0)};
      directed = {directed, column_row(64'h0, 1'b1)};
      // oversized height clamps to the full word
      directed = {directed, write_row(RegColumnHeight, 7'd127)};
      directed = {directed, write_row(RegBorderAlive, 7'd0)};
      directed = {directed, column_row(64'hC3C3_3C3C_9669_6996, 1'b0)};
      directed = {directed, column_row(64'h0F0F_F0F0_1248_8421, 1'b1)};
      directed = {directed, write_row(RegColumnHeight, 7'd1)};
      directed = {directed, column_row(64'h1, 1'b0)};
      directed = {directed, column_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b1)};
      // rule change with a column still held
      directed = {directed, column_row(64'h0000_FFFF_0000_FFFF, 1'b0)};
      directed = {directed, write_row(RegBorderAlive, 7'd1)};
      directed = {directed, column_row(64'h3333_CCCC_3333_CCCC, 1'b0)};
      directed = {directed, column_row(64'hAAAA_5555_AAAA_5555, 1'b1)};

      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].is_write) begin
            settle();
            write_reg(directed[i].reg_index, directed[i].reg_value);
         end else begin
            send_column(directed[i].column, directed[i].last, directed[i].known,
                        directed[i].known_bits);
         end
      end

      for (int phase = 0; phase < PhaseCount; phase++) begin
         settle();
         height_pick = $urandom_range(0, 3);
         case (height_pick)
            0: write_reg(RegColumnHeight, CsrDataWidth'($urandom_range(0, 127)));
            1: write_reg(RegColumnHeight, CsrDataWidth'($urandom_range(1, 8)));
            default: write_reg(RegColumnHeight, CsrDataWidth'($urandom_range(48, 64)));
         endcase
         write_reg(RegSurviveMin, random_threshold());
         write_reg(RegBirthMin, random_threshold());
         write_reg(RegBorderAlive, CsrDataWidth'($urandom_range(0, 127)));
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 58; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin send_idle_pct = 28; rsp_stall_pct = 28; end
         endcase
         sent = 0;
         while (sent < PhaseItems) begin
            grid_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
            for (int k = 0; k < grid_len; k++)
               send_column(random_column(), k == grid_len - 1, 1'b0, '0);
            sent += grid_len;
         end
      end

      req_tvalid = 1'b0;
      while (awaited_columns.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (awaited_columns.size() != 0)
         report($sformatf("%0d results never arrived", awaited_columns.size()));
      if (fault_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
